>>> src/framed_command_receiver_with_reply_top_assert.svh
// ----------------------------------------------------------------------------
// Framed command receiver assertion macros
// Shorthand for clocked implication checks used by the checker module.
// ----------------------------------------------------------------------------
`ifndef FRAMED_COMMAND_RECEIVER_WITH_REPLY_TOP_ASSERT_SVH
`define FRAMED_COMMAND_RECEIVER_WITH_REPLY_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst is high
`define FCR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high
`define FCR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/fcr_pkg.sv
// ----------------------------------------------------------------------------
// Framed command receiver package
// Shared constants: sync bytes, command codes, store offsets, status codes.
// ----------------------------------------------------------------------------
package fcr_pkg;

  // Default sizes
  localparam int STORE_BYTES_DEF = 32;
  localparam int MAX_PAYLOAD_DEF = 255;

  // Frame sync pair
  localparam logic [7:0] SYNC_A = 8'hFF;
  localparam logic [7:0] SYNC_B = 8'hAA;

  // Command codes
  localparam logic [7:0] CMD_IGNORED = 8'd128;
  localparam logic [7:0] CMD_WR_BASE = 8'd1;
  localparam logic [7:0] CMD_WR_CFG  = 8'd2;
  localparam logic [7:0] CMD_WR_HI   = 8'd4;
  localparam logic [7:0] CMD_WR_TOP  = 8'd5;

  // Store byte offsets per write command
  localparam logic [7:0] OFF_BASE = 8'd0;
  localparam logic [7:0] OFF_CFG  = 8'd4;
  localparam logic [7:0] OFF_HI   = 8'd20;
  localparam logic [7:0] OFF_TOP  = 8'd24;

  // Frame status codes
  localparam logic [2:0] STAT_REPLIED   = 3'd0;
  localparam logic [2:0] STAT_APPLIED   = 3'd1;
  localparam logic [2:0] STAT_BAD_SUM   = 3'd2;
  localparam logic [2:0] STAT_IGNORED   = 3'd3;
  localparam logic [2:0] STAT_HDR_REJECT = 3'd4;

  // Result kinds
  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_REPLY  = 1'b1;

  // Configuration register indexes
  localparam logic REG_QUERY_CODE = 1'b0;
  localparam logic REG_REPLY_CODE = 1'b1;

  // Reset values of configuration registers
  localparam logic [7:0] QUERY_CODE_RST = 8'd0;
  localparam logic [7:0] REPLY_CODE_RST = 8'd128;

endpackage

>>> src/framed_command_receiver_with_reply_top.sv
// A byte that causes no result is taken with no stall, and ready stays high.
// Checksum byte: the copy sweep reads then writes each stored byte (one read port
// on the pending-payload memory), then the reply sweep addresses the store's
// registered read port and emits each of STORE_BYTES+9 beats, then the status beat.
// Header reject: the status beat alone; m_tready stalls delay beats. Reset is synchronous
// and clears the store's valid bits at once; there is no clearing pass.
// ----------------------------------------------------------------------------
// Framed command receiver with reply
// Parses sync-framed commands byte by byte, applies payload writes to a
// parameter store after an additive checksum check, and streams a reply frame
// for query and replying write commands plus one status beat per frame.
// ----------------------------------------------------------------------------
module framed_command_receiver_with_reply_top
  import fcr_pkg::*;
#(
  parameter int STORE_BYTES = STORE_BYTES_DEF,
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // Input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  // Output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [2:0] status, [10:3] tx_byte, [15:11] zero
  output logic [0:0]  m_tuser,   // [0] kind
  output logic        m_tlast,   // last
  // Configuration
  input  logic        cfg_we,
  input  logic        cfg_idx,
  input  logic [7:0]  cfg_wdata
);

  localparam int SIDX_W = $clog2(STORE_BYTES);
  localparam int PIDX_W = $clog2(MAX_PAYLOAD);
  localparam int RCNT_W = $clog2(STORE_BYTES + 9);
  localparam logic [RCNT_W-1:0] HDR_BEATS = RCNT_W'(8);
  localparam logic [RCNT_W-1:0] SUM_BEAT  = RCNT_W'(STORE_BYTES + 8);

  typedef enum logic [3:0] {
    PH_HUNT_A, PH_HUNT_B, PH_CMD, PH_ZERO, PH_LEN, PH_RSV, PH_PAY, PH_SUM
  } ph_t;

  typedef enum logic [2:0] {
    SQ_IDLE, SQ_COPY_RD, SQ_COPY_WR, SQ_REP_RD, SQ_REP_OUT, SQ_STATUS
  } sq_t;

  ph_t         phase;
  sq_t         seq;
  logic [7:0]  query_code;
  logic [7:0]  reply_code;
  logic [7:0]  byte_pos;
  logic [7:0]  frame_cmd;
  logic [7:0]  pay_len;
  logic [7:0]  run_sum;
  logic [2:0]  stat_code;
  logic        do_reply;
  logic [7:0]  wr_off;
  logic [7:0]  cidx;
  logic [RCNT_W-1:0] rcnt;
  logic [7:0]  rsum;

  logic [2:0]  out_status;
  logic [7:0]  out_tx;
  logic        out_kind;

  // Memories
  logic [7:0]  pend_mem [MAX_PAYLOAD];
  logic [7:0]  pend_rdata;
  logic [7:0]  store_mem [STORE_BYTES];
  logic        store_vld [STORE_BYTES];
  logic [7:0]  store_rdata;
  logic        store_rvld;

  logic        accept;
  logic        slot_free;
  logic        out_load;
  logic        pend_we;
  logic [PIDX_W-1:0] pend_waddr;
  logic [PIDX_W-1:0] pend_raddr;
  logic        store_we;
  logic [SIDX_W-1:0] store_waddr;
  logic [SIDX_W-1:0] store_raddr;
  logic [RCNT_W-1:0] store_roff;
  logic [8:0]  copy_addr;
  logic        copy_more;
  logic [8:0]  pos_inc;

  logic [2:0]  dec_status;
  logic        dec_write;
  logic        dec_reply;
  logic [7:0]  dec_off;
  logic [7:0]  rep_byte;

  assign s_tready  = (seq == SQ_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign slot_free = !m_tvalid || m_tready;
  assign out_load  = slot_free && ((seq == SQ_REP_OUT) || (seq == SQ_STATUS));

  assign m_tdata   = {5'd0, out_tx, out_status};
  assign m_tuser   = out_kind;

  assign pos_inc   = {1'b0, byte_pos} + 9'd1;
  assign copy_addr = {1'b0, wr_off} + {1'b0, cidx};
  assign copy_more = (cidx < pay_len) && (copy_addr < 9'(STORE_BYTES));

  // Memory ports
  assign pend_we     = accept && (phase == PH_PAY);
  assign pend_waddr  = byte_pos[PIDX_W-1:0];
  assign pend_raddr  = cidx[PIDX_W-1:0];
  assign store_we    = (seq == SQ_COPY_WR);
  assign store_waddr = copy_addr[SIDX_W-1:0];
  assign store_roff  = rcnt - HDR_BEATS;
  assign store_raddr = store_roff[SIDX_W-1:0];

  // Decide what a finished frame does
  always_comb begin
    dec_status = STAT_IGNORED;
    dec_write  = 1'b0;
    dec_reply  = 1'b0;
    dec_off    = OFF_BASE;
    if (frame_cmd == CMD_IGNORED) begin
      dec_status = STAT_IGNORED;
    end else if (s_tdata != run_sum) begin
      dec_status = STAT_BAD_SUM;
    end else if (frame_cmd == query_code) begin
      dec_status = STAT_REPLIED;
      dec_reply  = 1'b1;
    end else if (frame_cmd == CMD_WR_BASE || frame_cmd == CMD_WR_CFG) begin
      dec_status = STAT_REPLIED;
      dec_write  = 1'b1;
      dec_reply  = 1'b1;
      dec_off    = (frame_cmd == CMD_WR_BASE) ? OFF_BASE : OFF_CFG;
    end else if (frame_cmd == CMD_WR_HI || frame_cmd == CMD_WR_TOP) begin
      dec_status = STAT_APPLIED;
      dec_write  = 1'b1;
      dec_off    = (frame_cmd == CMD_WR_HI) ? OFF_HI : OFF_TOP;
    end
  end

  // Select the reply beat for the current count
  always_comb begin
    rep_byte = rsum;
    if (rcnt < HDR_BEATS) begin
      case (rcnt[2:0])
        3'd0:    rep_byte = SYNC_A;
        3'd1:    rep_byte = SYNC_B;
        3'd2:    rep_byte = reply_code;
        3'd4:    rep_byte = 8'(STORE_BYTES);
        default: rep_byte = 8'd0;
      endcase
    end else if (rcnt < SUM_BEAT) begin
      rep_byte = store_rvld ? store_rdata : 8'd0;
    end
  end

  // Pending payload memory: write during payload, read during copy sweep
  always_ff @(posedge clk) begin
    if (pend_we) begin
      pend_mem[pend_waddr] <= s_tdata;
    end
    pend_rdata <= pend_mem[pend_raddr];
  end

  // Parameter store memory with registered read
  always_ff @(posedge clk) begin
    if (store_we) begin
      store_mem[store_waddr] <= pend_rdata;
    end
    store_rdata <= store_mem[store_raddr];
  end

  // Store valid bits: unwritten entries read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < STORE_BYTES; i++) begin
        store_vld[i] <= 1'b0;
      end
    end else if (store_we) begin
      store_vld[store_waddr] <= 1'b1;
    end
    store_rvld <= store_vld[store_raddr];
  end

  // Frame parser, sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HUNT_A;
      seq        <= SQ_IDLE;
      query_code <= QUERY_CODE_RST;
      reply_code <= REPLY_CODE_RST;
      byte_pos   <= 8'd0;
      frame_cmd  <= 8'd0;
      pay_len    <= 8'd0;
      run_sum    <= 8'd0;
      m_tvalid   <= 1'b0;
    end else begin
      // Register writes
      if (cfg_we) begin
        unique case (cfg_idx)
          REG_QUERY_CODE: query_code <= cfg_wdata;
          REG_REPLY_CODE: reply_code <= cfg_wdata;
        endcase
      end

      // Raise valid on a new beat, drop a taken beat
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      unique case (seq)
        SQ_IDLE: begin
          if (accept) begin
            unique case (phase)
              PH_HUNT_A: begin
                if (s_tdata == SYNC_A) begin
                  run_sum <= s_tdata;
                  phase   <= PH_HUNT_B;
                end
              end
              PH_HUNT_B: begin
                if (s_tdata == SYNC_B) begin
                  run_sum <= run_sum + s_tdata;
                  phase   <= PH_CMD;
                end else if (s_tdata == SYNC_A) begin
                  run_sum <= s_tdata;
                end else begin
                  phase <= PH_HUNT_A;
                end
              end
              PH_CMD: begin
                frame_cmd <= s_tdata;
                run_sum   <= run_sum + s_tdata;
                phase     <= PH_ZERO;
              end
              PH_ZERO: begin
                if (s_tdata != 8'd0) begin
                  stat_code <= STAT_HDR_REJECT;
                  phase     <= PH_HUNT_A;
                  seq       <= SQ_STATUS;
                end else begin
                  phase <= PH_LEN;
                end
              end
              PH_LEN: begin
                if (s_tdata > 8'(MAX_PAYLOAD)) begin
                  stat_code <= STAT_HDR_REJECT;
                  phase     <= PH_HUNT_A;
                  seq       <= SQ_STATUS;
                end else begin
                  pay_len  <= s_tdata;
                  run_sum  <= run_sum + s_tdata;
                  byte_pos <= 8'd0;
                  phase    <= PH_RSV;
                end
              end
              PH_RSV: begin
                run_sum <= run_sum + s_tdata;
                if (byte_pos == 8'd2) begin
                  byte_pos <= 8'd0;
                  phase    <= (pay_len != 8'd0) ? PH_PAY : PH_SUM;
                end else begin
                  byte_pos <= pos_inc[7:0];
                end
              end
              PH_PAY: begin
                run_sum  <= run_sum + s_tdata;
                byte_pos <= pos_inc[7:0];
                if (pos_inc >= {1'b0, pay_len}) begin
                  phase <= PH_SUM;
                end
              end
              PH_SUM: begin
                stat_code <= dec_status;
                do_reply  <= dec_reply;
                wr_off    <= dec_off;
                cidx      <= 8'd0;
                rcnt      <= '0;
                rsum      <= 8'd0;
                phase     <= PH_HUNT_A;
                if (dec_write) begin
                  seq <= SQ_COPY_RD;
                end else if (dec_reply) begin
                  seq <= SQ_REP_RD;
                end else begin
                  seq <= SQ_STATUS;
                end
              end
              default: phase <= PH_HUNT_A;
            endcase
          end
        end

        // Copy sweep: read pending entry, then write it to the store
        SQ_COPY_RD: begin
          if (copy_more) begin
            seq <= SQ_COPY_WR;
          end else begin
            seq <= do_reply ? SQ_REP_RD : SQ_STATUS;
          end
        end
        SQ_COPY_WR: begin
          cidx <= cidx + 8'd1;
          seq  <= SQ_COPY_RD;
        end

        // Reply sweep: address the store, then emit one beat
        SQ_REP_RD: begin
          seq <= SQ_REP_OUT;
        end
        SQ_REP_OUT: begin
          if (slot_free) begin
            out_kind   <= KIND_REPLY;
            out_status <= STAT_REPLIED;
            out_tx     <= rep_byte;
            m_tlast    <= 1'b0;
            rsum       <= rsum + rep_byte;
            if (rcnt == SUM_BEAT) begin
              seq <= SQ_STATUS;
            end else begin
              rcnt <= rcnt + RCNT_W'(1);
              seq  <= SQ_REP_RD;
            end
          end
        end

        // Close the frame with its status beat
        SQ_STATUS: begin
          if (slot_free) begin
            out_kind   <= KIND_STATUS;
            out_status <= stat_code;
            out_tx     <= 8'd0;
            m_tlast    <= 1'b1;
            seq        <= SQ_IDLE;
          end
        end

        default: seq <= SQ_IDLE;
      endcase
    end
  end

endmodule

>>> src/fcr_checker.sv
// ----------------------------------------------------------------------------
// Framed command receiver port checker
// Watches the top level's ports for result framing and stall behavior.
// ----------------------------------------------------------------------------
`include "framed_command_receiver_with_reply_top_assert.svh"

module fcr_checker
  import fcr_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic [0:0]  m_tuser,
  input logic        m_tlast
);

  logic stalled;
  logic reply_beat;
  logic status_beat;
  logic reply_ok;
  logic status_ok;

  assign stalled     = m_tvalid && !m_tready;
  assign reply_beat  = m_tvalid && (m_tuser[0] == KIND_REPLY);
  assign status_beat = m_tvalid && (m_tuser[0] == KIND_STATUS);
  assign reply_ok    = !m_tlast && (m_tdata[2:0] == STAT_REPLIED);
  assign status_ok   = m_tlast && (m_tdata[15:3] == 13'd0) && (m_tdata[2:0] <= STAT_HDR_REJECT);

  // Hold a stalled result beat
  `FCR_ASSERT_NEXT(a_stall_hold, stalled, m_tvalid && $stable({m_tdata, m_tuser, m_tlast}), "stalled beat changed")

  // Reply bytes never close a step and carry the replied status code
  `FCR_ASSERT_NOW(a_reply_form, reply_beat, reply_ok, "bad reply beat")

  // Status beats close the step with a legal code and no byte
  `FCR_ASSERT_NOW(a_status_form, status_beat, status_ok, "bad status beat")

  // No input is taken while a reply is being sent
  `FCR_ASSERT_NOW(a_reply_blocks_in, reply_beat, !s_tready, "input ready during reply")

endmodule

bind framed_command_receiver_with_reply_top fcr_checker u_fcr_checker (.*);

>>> dv/framed_command_receiver_with_reply_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Framed command receiver with reply testbench
// Feeds sync-framed command bytes (clean frames, bad checksums, broken
// headers and line noise) under random gaps and output stalls, tracks the
// parser and parameter store on the side, and checks every reply and
// status beat against the tracked outcome.
// ----------------------------------------------------------------------------
module framed_command_receiver_with_reply_top_tb;
  import fcr_pkg::*;

  localparam int STORE_N     = STORE_BYTES_DEF;
  localparam int QUIET_LIMIT = 4000;

  typedef enum logic [2:0] {
    P_SYNC_A, P_SYNC_B, P_CMD, P_ZERO, P_LEN, P_RSV, P_PAY, P_SUM
  } parse_phase_t;

  typedef struct packed {
    logic       kind;
    logic [2:0] status;
    logic [7:0] tx_byte;
    logic       last;
  } out_beat_t;

  logic        clk;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata   = 8'h00;   // [7:0] rx_byte
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [15:0] m_tdata;             // [2:0] status, [10:3] tx_byte, [15:11] zero
  logic [0:0]  m_tuser;             // [0] kind
  logic        m_tlast;
  logic        cfg_we    = 1'b0;
  logic        cfg_idx   = REG_QUERY_CODE;
  logic [7:0]  cfg_wdata = 8'h00;

  // Tracked parser state, registers and store
  parse_phase_t rx_phase    = P_SYNC_A;
  logic [7:0]   hdr_pos     = 8'h00;
  logic [7:0]   frame_cmd   = 8'h00;
  logic [7:0]   frame_len   = 8'h00;
  logic [7:0]   frame_sum   = 8'h00;
  logic [7:0]   model_query = QUERY_CODE_RST;
  logic [7:0]   model_reply = REPLY_CODE_RST;
  logic [7:0]   model_store [STORE_N];
  logic [7:0]   payload_buf [MAX_PAYLOAD_DEF];

  out_beat_t due_beats[$];

  bit gapless         = 1'b0;
  int hold_off_cycles = 0;
  int quiet_cycles    = 0;
  int fail_count      = 0;
  int rx_count        = 0;
  int beat_count      = 0;
  int frame_count     = 0;
  int setting_count   = 1;

  framed_command_receiver_with_reply_top dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    foreach (model_store[i]) model_store[i] = 8'h00;
  end

  function automatic int draw_gap();
    return gapless ? 0 : $urandom_range(0, 19);
  endfunction

  // ---------------------------------------------------------------------------
  // Expected beats
  // ---------------------------------------------------------------------------
  function automatic void push_reply_byte(input logic [7:0] b, inout logic [7:0] sum);
    out_beat_t e;
    e = '{kind: KIND_REPLY, status: STAT_REPLIED, tx_byte: b, last: 1'b0};
    sum = sum + b;
    due_beats.push_back(e);
  endfunction

  // Header, whole store, then additive checksum of all of it
  function automatic void push_reply_frame();
    logic [7:0] sum;
    out_beat_t  e;
    sum = 8'h00;
    push_reply_byte(SYNC_A, sum);
    push_reply_byte(SYNC_B, sum);
    push_reply_byte(model_reply, sum);
    push_reply_byte(8'h00, sum);
    push_reply_byte(8'(STORE_N), sum);
    push_reply_byte(8'h00, sum);
    push_reply_byte(8'h00, sum);
    push_reply_byte(8'h00, sum);
    for (int i = 0; i < STORE_N; i++) push_reply_byte(model_store[i], sum);
    e = '{kind: KIND_REPLY, status: STAT_REPLIED, tx_byte: sum, last: 1'b0};
    due_beats.push_back(e);
  endfunction

  // The status beat always closes the results of its byte
  function automatic void push_status(input logic [2:0] st);
    out_beat_t e;
    e = '{kind: KIND_STATUS, status: st, tx_byte: 8'h00, last: 1'b1};
    due_beats.push_back(e);
  endfunction

  // Drop payload bytes that land past the store end
  function automatic void store_payload(input logic [7:0] off);
    for (int i = 0; i < int'(frame_len); i++) begin
      if (int'(off) + i < STORE_N) model_store[int'(off) + i] = payload_buf[i];
    end
  endfunction

  function automatic void close_frame(input logic [7:0] check);
    logic [2:0] st;
    if (frame_cmd == CMD_IGNORED) begin
      st = STAT_IGNORED;
    end else if (check != frame_sum) begin
      st = STAT_BAD_SUM;
    end else if (frame_cmd == model_query) begin
      // Query wins over a write command with the same code
      push_reply_frame();
      st = STAT_REPLIED;
    end else if (frame_cmd == CMD_WR_BASE || frame_cmd == CMD_WR_CFG) begin
      store_payload(frame_cmd == CMD_WR_BASE ? OFF_BASE : OFF_CFG);
      push_reply_frame();
      st = STAT_REPLIED;
    end else if (frame_cmd == CMD_WR_HI || frame_cmd == CMD_WR_TOP) begin
      store_payload(frame_cmd == CMD_WR_HI ? OFF_HI : OFF_TOP);
      st = STAT_APPLIED;
    end else begin
      st = STAT_IGNORED;
    end
    push_status(st);
  endfunction

  // Advance the tracked parser by one accepted byte
  function automatic void parse_rx_byte(input logic [7:0] b);
    case (rx_phase)
      P_SYNC_A: begin
        if (b == SYNC_A) begin
          frame_sum = b;
          rx_phase  = P_SYNC_B;
        end
      end
      P_SYNC_B: begin
        if (b == SYNC_B) begin
          frame_sum = frame_sum + b;
          rx_phase  = P_CMD;
        end else if (b == SYNC_A) begin
          frame_sum = b;
        end else begin
          rx_phase = P_SYNC_A;
        end
      end
      P_CMD: begin
        frame_cmd = b;
        frame_sum = frame_sum + b;
        rx_phase  = P_ZERO;
      end
      P_ZERO: begin
        if (b != 8'h00) begin
          push_status(STAT_HDR_REJECT);
          rx_phase = P_SYNC_A;
        end else begin
          rx_phase = P_LEN;
        end
      end
      P_LEN: begin
        // An 8-bit length never exceeds the payload limit of 255
        frame_len = b;
        frame_sum = frame_sum + b;
        hdr_pos   = 8'h00;
        rx_phase  = P_RSV;
      end
      P_RSV: begin
        frame_sum = frame_sum + b;
        hdr_pos   = hdr_pos + 8'd1;
        if (hdr_pos >= 8'd3) begin
          hdr_pos  = 8'h00;
          rx_phase = (frame_len != 8'h00) ? P_PAY : P_SUM;
        end
      end
      P_PAY: begin
        payload_buf[hdr_pos] = b;
        frame_sum = frame_sum + b;
        hdr_pos   = hdr_pos + 8'd1;
        if (hdr_pos >= frame_len) rx_phase = P_SUM;
      end
      default: begin
        close_frame(b);
        rx_phase = P_SYNC_A;
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------
  // Hold valid across back-to-back beats; lower it only for a gap
  task automatic send_rx_byte(input logic [7:0] b);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    rx_count++;
    parse_rx_byte(b);
  endtask

  task automatic send_frame(input logic [7:0] cmd, input int len, input bit good_sum);
    logic [7:0] bytes[$];
    logic [7:0] sum;
    bytes = '{SYNC_A, SYNC_B, cmd, 8'h00, 8'(len)};
    repeat (3) bytes.push_back(8'($urandom_range(0, 255)));
    repeat (len) bytes.push_back(8'($urandom_range(0, 255)));
    sum = 8'h00;
    foreach (bytes[i]) sum = sum + bytes[i];
    if (!good_sum) sum = sum + 8'($urandom_range(1, 255));
    bytes.push_back(sum);
    foreach (bytes[i]) send_rx_byte(bytes[i]);
    frame_count++;
  endtask

  // Feed zeros until the parser is back to hunting
  task automatic flush_parser();
    while (rx_phase != P_SYNC_A) send_rx_byte(8'h00);
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (due_beats.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    if (idx == REG_QUERY_CODE) model_query = val;
    else model_reply = val;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_setting(input logic [7:0] query, input logic [7:0] reply);
    wait_idle();
    write_reg(REG_QUERY_CODE, query);
    write_reg(REG_REPLY_CODE, reply);
    setting_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Output side: random stall per beat, optional long hold-off, check
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int gap;
    out_beat_t e;
    while (rst) @(posedge clk);
    forever begin
      if (hold_off_cycles > 0) begin
        m_tready <= 1'b0;
        for (int c = 0; c < hold_off_cycles; c++) @(posedge clk);
        hold_off_cycles = 0;
      end
      gap = draw_gap();
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      beat_count++;
      if (due_beats.size() == 0) begin
        $error("unexpected beat: kind %0d status %0d tx_byte %02h last %0d",
               m_tuser[0], m_tdata[2:0], m_tdata[10:3], m_tlast);
        fail_count++;
      end else begin
        e = due_beats.pop_front();
        if (m_tuser[0] !== e.kind) begin
          $error("kind: expected %0d, got %0d", e.kind, m_tuser[0]);
          fail_count++;
        end
        if (m_tdata[2:0] !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, m_tdata[2:0]);
          fail_count++;
        end
        if (m_tdata[10:3] !== e.tx_byte) begin
          $error("tx_byte: expected %02h, got %02h", e.tx_byte, m_tdata[10:3]);
          fail_count++;
        end
        if (m_tlast !== e.last) begin
          $error("last: expected %0d, got %0d", e.last, m_tlast);
          fail_count++;
        end
      end
    end
  end

  // Stop a hung run: count cycles with no beat on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Noise, restarted sync, zero-length query, broken sync, header reject,
  // ignored command read to its end with a bad checksum
  task automatic test_directed_frames();
    send_rx_byte(8'h00);
    send_rx_byte(SYNC_A);
    send_frame(model_query, 0, 1'b1);
    send_rx_byte(SYNC_A);
    send_rx_byte(8'h55);
    send_rx_byte(SYNC_A);
    send_rx_byte(SYNC_B);
    send_rx_byte(CMD_IGNORED);
    send_rx_byte(8'h01);
    send_frame(CMD_IGNORED, 0, 1'b0);
  endtask

  // Mostly well-formed frames with random content, some broken ones and noise
  task automatic test_random_traffic(input int budget);
    int start;
    int pick;
    int len;
    logic [7:0] cmd;
    start = rx_count;
    while (rx_count - start < budget) begin
      gapless = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        pick = $urandom_range(0, 99);
        if (pick < 20)      cmd = CMD_WR_BASE;
        else if (pick < 40) cmd = CMD_WR_CFG;
        else if (pick < 52) cmd = CMD_WR_HI;
        else if (pick < 64) cmd = CMD_WR_TOP;
        else if (pick < 76) cmd = model_query;
        else if (pick < 84) cmd = CMD_IGNORED;
        else                cmd = 8'($urandom_range(0, 255));
        len = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 8) : $urandom_range(9, 40);
        send_frame(cmd, len, $urandom_range(0, 9) != 0);
      end else if (pick < 82) begin
        send_rx_byte(SYNC_A);
        send_rx_byte(SYNC_B);
        send_rx_byte(8'($urandom_range(0, 255)));
        send_rx_byte(8'($urandom_range(1, 255)));
      end else begin
        repeat ($urandom_range(1, 6)) begin
          if ($urandom_range(0, 3) == 0)
            send_rx_byte($urandom_range(0, 1) ? SYNC_A : SYNC_B);
          else
            send_rx_byte(8'($urandom_range(0, 255)));
        end
      end
    end
    gapless = 1'b0;
    flush_parser();
  endtask

  // Stall the output for a long stretch while replying frames keep coming
  task automatic test_output_hold_off();
    gapless = 1'b1;
    hold_off_cycles = 300;
    repeat (4) send_frame(CMD_WR_CFG, 3, 1'b1);
    gapless = 1'b0;
  endtask

  // Long payload from the store start: fills the whole store, drops the rest
  task automatic test_max_length_frame();
    send_frame(CMD_WR_BASE, 100, 1'b1);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_frames();
    test_random_traffic(30);

    apply_setting(8'hFF, 8'h00);
    test_random_traffic(25);

    apply_setting(CMD_WR_BASE, 8'hFF);
    test_random_traffic(25);

    apply_setting(CMD_WR_TOP, 8'($urandom_range(0, 255)));
    test_random_traffic(20);

    apply_setting(CMD_IGNORED, REPLY_CODE_RST);
    test_output_hold_off();
    test_random_traffic(20);

    apply_setting(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    test_max_length_frame();
    test_random_traffic(20);

    wait_idle();
    repeat (100) @(posedge clk);

    $display("Drove %0d input bytes in %0d built frames plus noise, checked %0d result beats,",
             rx_count, frame_count, beat_count);
    $display("over %0d register settings with random stalls and one long output hold-off.",
             setting_count);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> framed_command_receiver_with_reply_top.f
+incdir+src
src/fcr_pkg.sv
src/framed_command_receiver_with_reply_top.sv
src/fcr_checker.sv
dv/framed_command_receiver_with_reply_top_tb.sv
